### rtl/length_prefixed_frame_parser_core_defines.svh
// Assertion macros used by the frame parser top level.
`ifndef LENGTH_PREFIXED_FRAME_PARSER_CORE_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LPFP_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LPFP_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/lpfp_pkg.sv
// Types and constants of the length-prefixed frame parser.
package lpfp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned ChkW     = 16;
  localparam int unsigned OutLenW  = 6;
  localparam int unsigned OutIdxW  = 5;
  localparam int unsigned MTdataW  = 48;
  localparam int unsigned CfgIdxW  = 2;

  typedef enum logic [3:0] {
    PH_HEAD1,
    PH_HEAD2,
    PH_ID,
    PH_LEN,
    PH_DATA,
    PH_CHK1,
    PH_CHK2,
    PH_TAIL1,
    PH_TAIL2
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEAD_FIRST  = 2'd0,
    CFG_HEAD_SECOND = 2'd1,
    CFG_TAIL_FIRST  = 2'd2,
    CFG_TAIL_SECOND = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [ByteW-1:0] head_first;
    logic [ByteW-1:0] head_second;
    logic [ByteW-1:0] tail_first;
    logic [ByteW-1:0] tail_second;
  } cfg_t;

  // Frame handed from the parser to the emitter.
  typedef struct packed {
    logic             start;
    logic [ByteW-1:0] id;
    logic [ChkW-1:0]  chk;
  } frame_info_t;

endpackage

### rtl/length_prefixed_frame_parser_core.sv
// Length-prefixed frame parser: top level with config registers and assertions.
//
// Usage: received serial bytes enter one per transfer on the s_axis channel.
// The parser hunts for two header bytes, takes an ID byte and a length byte,
// stores up to DATA_DEPTH payload bytes, then a 16-bit check word (high byte
// first, not verified) and two trailer bytes. When both trailer bytes match,
// the frame leaves on m_axis as one transfer per payload byte (one transfer
// with a zero byte for an empty frame), tlast on the final one.
// Rate: one input byte per cycle while parsing. The first result appears in
// the cycle after the second trailer byte is taken (the payload memory read);
// after that one result per cycle while m_axis_tready is high, and a frame
// of N bytes gives max(N,1) results. s_axis_tready is low while results are
// pending, so new payload bytes cannot overwrite entries still being read.
// When the receiver stalls, the current result holds and the read of the
// next entry waits. Reset (async, active low) returns to hunting, clears the
// held frame fields and the header/trailer registers; the payload memory is
// not cleared, only entries written in the current frame are read.
// Config writes (cfg_index_i: 0 head_first, 1 head_second, 2 tail_first,
// 3 tail_second) are always accepted.
`include "length_prefixed_frame_parser_core_defines.svh"
module length_prefixed_frame_parser_core import lpfp_pkg::*; #(
  parameter int unsigned DATA_DEPTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // tdata: rx_byte[7:0]
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [ByteW-1:0]   s_axis_tdata,
  // tdata: pkt_id[7:0], payload_length[13:8], payload_byte[21:14],
  //        payload_index[26:22], check_word[42:27], zero pad[47:43]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [MTdataW-1:0] m_axis_tdata,
  output logic               m_axis_tlast,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_data_i
);

  localparam int unsigned AddrW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
  localparam int unsigned LenW  = $clog2(DATA_DEPTH + 1);

  cfg_t             cfg_q;
  logic             byte_xfer;
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [ByteW-1:0] wdata;
  logic             re;
  logic [AddrW-1:0] raddr;
  logic [ByteW-1:0] rdata;
  frame_info_t      frame;
  logic [LenW-1:0]  len;
  logic             emit_busy;
  logic             out_xfer;
  logic             out_last;

  // Header/trailer match values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_HEAD_FIRST:  cfg_q.head_first  <= cfg_data_i;
        CFG_HEAD_SECOND: cfg_q.head_second <= cfg_data_i;
        CFG_TAIL_FIRST:  cfg_q.tail_first  <= cfg_data_i;
        CFG_TAIL_SECOND: cfg_q.tail_second <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o   = 1'b1;
  // Input is held off while the memory is being read out.
  assign s_axis_tready = !emit_busy;
  assign byte_xfer     = s_axis_tvalid && s_axis_tready;

  lpfp_parser #(
    .DEPTH (DATA_DEPTH),
    .ADDR_W(AddrW),
    .LEN_W (LenW)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .byte_valid_i(byte_xfer),
    .byte_i      (s_axis_tdata),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .frame_o     (frame),
    .len_o       (len)
  );

  // Writes and reads never overlap: no input transfer while emitting.
  lpfp_store #(
    .DEPTH (DATA_DEPTH),
    .ADDR_W(AddrW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  lpfp_emit #(
    .ADDR_W(AddrW),
    .LEN_W (LenW)
  ) u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .frame_i  (frame),
    .len_i    (len),
    .rdata_i  (rdata),
    .re_o     (re),
    .raddr_o  (raddr),
    .busy_o   (emit_busy),
    .m_valid_o(m_axis_tvalid),
    .m_ready_i(m_axis_tready),
    .m_data_o (m_axis_tdata),
    .m_last_o (m_axis_tlast)
  );

  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign out_last = out_xfer && m_axis_tlast;

  `LPFP_ASSERT_NOW(a_no_write_while_emit, we, !emit_busy, "payload write during emission")
  `LPFP_ASSERT_NEXT(a_last_ends_frame, out_last, !m_axis_tvalid, "valid after tlast")
  `LPFP_ASSERT_NEXT(a_frame_continues, out_xfer && !out_last, m_axis_tvalid, "frame cut early")
  `LPFP_ASSERT_NEXT(a_start_emits, frame.start, m_axis_tvalid && !s_axis_tready, "no emission")

endmodule

### rtl/lpfp_store.sv
// Payload memory: one write port, one registered read port.
module lpfp_store import lpfp_pkg::*; #(
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = 5
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [ByteW-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [ByteW-1:0]  rdata_o
);

  logic [ByteW-1:0] mem [DEPTH];
  logic [ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds between reads.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/lpfp_parser.sv
// Byte-level frame parser: header hunt, ID, length, payload fill, check, trailer.
module lpfp_parser import lpfp_pkg::*; #(
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = 5,
  parameter int unsigned LEN_W  = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              byte_valid_i,
  input  logic [ByteW-1:0]  byte_i,
  output logic              we_o,
  output logic [ADDR_W-1:0] waddr_o,
  output logic [ByteW-1:0]  wdata_o,
  output frame_info_t       frame_o,
  output logic [LEN_W-1:0]  len_o
);

  localparam logic [ByteW-1:0] DepthByte = ByteW'(DEPTH);

  phase_e            phase_q, phase_d;
  logic [ByteW-1:0]  id_q, id_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [LEN_W-1:0]  fill_q, fill_d;
  logic [ChkW-1:0]   chk_q, chk_d;
  logic [LEN_W-1:0]  fill_inc;
  logic              start;

  assign fill_inc = fill_q + LEN_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEAD1;
      id_q    <= '0;
      len_q   <= '0;
      fill_q  <= '0;
      chk_q   <= '0;
    end else begin
      phase_q <= phase_d;
      id_q    <= id_d;
      len_q   <= len_d;
      fill_q  <= fill_d;
      chk_q   <= chk_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    id_d    = id_q;
    len_d   = len_q;
    fill_d  = fill_q;
    chk_d   = chk_q;
    we_o    = 1'b0;
    start   = 1'b0;
    if (byte_valid_i) begin
      unique case (phase_q)
        PH_HEAD1: begin
          if (byte_i == cfg_i.head_first) phase_d = PH_HEAD2;
        end
        PH_HEAD2: begin
          // mismatching byte is not retried as a first header byte
          phase_d = (byte_i == cfg_i.head_second) ? PH_ID : PH_HEAD1;
          id_d    = '0;
          len_d   = '0;
          fill_d  = '0;
          chk_d   = '0;
        end
        PH_ID: begin
          id_d    = byte_i;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          if (byte_i > DepthByte) begin
            phase_d = PH_HEAD1;
            id_d    = '0;
            len_d   = '0;
            chk_d   = '0;
          end else begin
            len_d   = byte_i[LEN_W-1:0];
            phase_d = (byte_i == '0) ? PH_CHK1 : PH_DATA;
          end
          fill_d = '0;
        end
        PH_DATA: begin
          we_o   = 1'b1;
          fill_d = fill_inc;
          if (fill_inc >= len_q) phase_d = PH_CHK1;
        end
        PH_CHK1: begin
          chk_d   = {byte_i, ByteW'(0)};
          phase_d = PH_CHK2;
        end
        PH_CHK2: begin
          chk_d   = {chk_q[ChkW-1:ByteW], byte_i};
          phase_d = PH_TAIL1;
        end
        PH_TAIL1: begin
          if (byte_i == cfg_i.tail_first) begin
            phase_d = PH_TAIL2;
          end else begin
            phase_d = PH_HEAD1;
            id_d    = '0;
            len_d   = '0;
            fill_d  = '0;
            chk_d   = '0;
          end
        end
        PH_TAIL2: begin
          start   = (byte_i == cfg_i.tail_second);
          phase_d = PH_HEAD1;
          id_d    = '0;
          len_d   = '0;
          fill_d  = '0;
          chk_d   = '0;
        end
        default: begin
          phase_d = PH_HEAD1;
        end
      endcase
    end
  end

  assign waddr_o       = fill_q[ADDR_W-1:0];
  assign wdata_o       = byte_i;
  assign frame_o.start = start;
  assign frame_o.id    = id_q;
  assign frame_o.chk   = chk_q;
  assign len_o         = len_q;

endmodule

### rtl/lpfp_emit.sv
// Result emitter: walks the payload memory one entry per output transfer.
module lpfp_emit import lpfp_pkg::*; #(
  parameter int unsigned ADDR_W = 5,
  parameter int unsigned LEN_W  = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  frame_info_t        frame_i,
  input  logic [LEN_W-1:0]   len_i,
  input  logic [ByteW-1:0]   rdata_i,
  output logic               re_o,
  output logic [ADDR_W-1:0]  raddr_o,
  output logic               busy_o,
  output logic               m_valid_o,
  input  logic               m_ready_i,
  output logic [MTdataW-1:0] m_data_o,
  output logic               m_last_o
);

  logic              valid_q, valid_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic [LEN_W-1:0]  len_q;
  logic [ByteW-1:0]  id_q;
  logic [ChkW-1:0]   chk_q;
  logic              last;
  logic              advance;
  logic [ByteW-1:0]  pay_byte;

  assign last    = (len_q == '0) || ((LEN_W'(idx_q) + LEN_W'(1)) == len_q);
  assign advance = valid_q && m_ready_i && !last;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (frame_i.start) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (valid_q && m_ready_i) begin
      valid_d = !last;
      idx_d   = idx_q + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_i.start) begin
      len_q <= len_i;
      id_q  <= frame_i.id;
      chk_q <= frame_i.chk;
    end
  end

  // Read of the next entry is issued with the transfer of the current one.
  assign re_o    = frame_i.start || advance;
  assign raddr_o = frame_i.start ? '0 : idx_q + ADDR_W'(1);

  assign pay_byte  = (len_q == '0) ? '0 : rdata_i;
  assign busy_o    = valid_q;
  assign m_valid_o = valid_q;
  assign m_last_o  = last;
  assign m_data_o  = {5'b0, chk_q, OutIdxW'(idx_q), pay_byte, OutLenW'(len_q), id_q};

endmodule
